// ===== rtl/r2sa_pkg.sv =====
// ----------------------------------------------------------------------------
// r2sa_pkg: shared types and constants of the R2 score accumulator
// Default sizes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package r2sa_pkg;

	localparam int MAX_SAMPLES_DEF = 65536;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// integer bits of the score, sign included (range -8.0 .. 1.0)
	localparam int R2_INT_BITS     = 4;
	localparam int COUNT_OUT_BITS  = 17;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_LOAD,
		ST_MUL_NSQ,
		ST_MUL_SS,
		ST_MUL_NRES,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MSEL_N_SQ,
		MSEL_S_S,
		MSEL_N_RES
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mul_load;
		mul_sel_t mul_sel;
		logic     mul_step;
		logic     den_set;
		logic     den_sub;
		logic     num_load;
		logic     check;
		logic     div_step;
		logic     div_frac;
		logic     div_shr;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic in_last;
		logic mul_done;
		logic skip_div;
	} status_t;

endpackage

// ===== rtl/r2sa_in_if.sv =====
// ----------------------------------------------------------------------------
// r2sa_in_if: sample pair channel
// Valid/ready channel carrying one true/predicted pair and the set end mark.
// ----------------------------------------------------------------------------
interface r2sa_in_if #(
	parameter int SAMPLE_BITS = r2sa_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] true_value;
	logic signed [SAMPLE_BITS-1:0] predicted_value;
	logic                          last;

	modport source (output valid, true_value, predicted_value, last, input ready);
	modport sink   (input valid, true_value, predicted_value, last, output ready);
endinterface

// ===== rtl/r2sa_out_if.sv =====
// ----------------------------------------------------------------------------
// r2sa_out_if: score channel
// Valid/ready channel carrying one R2 score with its flags and pair count.
// ----------------------------------------------------------------------------
interface r2sa_out_if #(
	parameter int FRAC_BITS = r2sa_pkg::FRAC_BITS_DEF
) ();
	logic                                               valid;
	logic                                               ready;
	logic signed [FRAC_BITS+r2sa_pkg::R2_INT_BITS-1:0]  r2_value;
	logic                                               saturated;
	logic                                               constant_target;
	logic                                               count_overflow;
	logic [r2sa_pkg::COUNT_OUT_BITS-1:0]                sample_count;

	modport source (output valid, r2_value, saturated, constant_target, count_overflow,
		sample_count, input ready);
	modport sink   (input valid, r2_value, saturated, constant_target, count_overflow,
		sample_count, output ready);
endinterface

// ===== rtl/r2sa_dp.sv =====
// ----------------------------------------------------------------------------
// r2sa_dp: accumulators, shift-add multiplier and restoring divider
// Squares each pair, sums count/true/true^2/residual^2, then forms
// den = n*sum_sq - sum^2 and num = n*ss_res and divides to a Q score.
// ----------------------------------------------------------------------------
module r2sa_dp #(
	parameter int MAX_SAMPLES = r2sa_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = r2sa_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = r2sa_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  r2sa_pkg::cmd_t        cmd,
	output r2sa_pkg::status_t     status,
	r2sa_in_if.sink               samples,
	r2sa_out_if.source            scores
);
	localparam int SW   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SW + CW;
	localparam int MPW  = SW + CW - 1;
	localparam int TSQW = 2 * SW + CW - 2;
	localparam int RESW = 2 * SW + CW;
	localparam int DENW = CW + TSQW;
	localparam int PW   = DENW + 2;
	localparam int REMW = DENW + 4;
	localparam int DVW  = DENW + 3;
	localparam int QW   = FRAC_BITS + r2sa_pkg::R2_INT_BITS;

	// per-pair products
	logic signed [SW:0]       diff;
	logic signed [2*SW-1:0]   tt;
	logic signed [2*SW+1:0]   dd;
	logic                     room;

	logic                     vld_s1;
	logic [2*SW-2:0]          tsq_s1;
	logic [2*SW-1:0]          rsq_s1;
	logic [SW-1:0]            t_s1;

	// accumulators
	logic [CW-1:0]            count_q;
	logic [SUMW-1:0]          sum_q;
	logic [TSQW-1:0]          tsq_q;
	logic [RESW-1:0]          res_q;
	logic                     ovf_q;

	// closing arithmetic
	logic [SUMW-1:0]          abs_full;
	logic [MPW-1:0]           abs_s;
	logic [PW-1:0]            mcand_q;
	logic [MPW-1:0]           mplier_q;
	logic [PW-1:0]            prod_q;
	logic [DENW-1:0]          den_q;
	logic [REMW-1:0]          rem_q;
	logic [DVW-1:0]           dvs_q;
	logic [QW-1:0]            quo_q;
	logic                     cst_q;
	logic                     sat_q;

	logic [REMW-1:0]          nine_den;
	logic                     den_zero;
	logic                     over;
	logic [REMW-1:0]          cand;
	logic [REMW-1:0]          dvs_ext;
	logic                     ge;

	logic [QW:0]              q_ceil;
	logic [QW:0]              r2_full;
	logic [QW-1:0]            r2_next;

	logic [QW-1:0]            r2_value_q;
	logic                     saturated_q;
	logic                     constant_q;
	logic                     overflow_q;
	logic [r2sa_pkg::COUNT_OUT_BITS-1:0] count_out_q;

	assign diff = {samples.true_value[SW-1], samples.true_value}
		- {samples.predicted_value[SW-1], samples.predicted_value};
	assign tt   = samples.true_value * samples.true_value;
	assign dd   = diff * diff;
	assign room = count_q < CW'(MAX_SAMPLES);

	assign abs_full = sum_q[SUMW-1] ? (~sum_q + SUMW'(1)) : sum_q;
	assign abs_s    = abs_full[MPW-1:0];

	assign nine_den = {den_q, 3'b000} + REMW'(den_q);
	assign den_zero = den_q == '0;
	assign over     = rem_q > nine_den;

	// integer steps compare against den<<3..den, fraction steps shift the remainder
	assign cand    = cmd.div_frac ? {rem_q[REMW-2:0], 1'b0} : rem_q;
	assign dvs_ext = REMW'(dvs_q);
	assign ge      = cand >= dvs_ext;

	assign q_ceil  = (QW+1)'(quo_q) + (QW+1)'(rem_q != '0);
	assign r2_full = ((QW+1)'(1) << FRAC_BITS) - q_ceil;

	always_comb begin
		if (cst_q) begin
			r2_next = QW'(1) << FRAC_BITS;
		end else if (sat_q) begin
			r2_next = {1'b1, {(QW-1){1'b0}}};
		end else begin
			r2_next = r2_full[QW-1:0];
		end
	end

	assign status.in_last  = samples.last;
	assign status.mul_done = mplier_q == '0;
	assign status.skip_div = den_zero || over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
			tsq_q   <= '0;
			res_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			vld_s1 <= cmd.accept && room;
			if (cmd.finish) begin
				count_q <= '0;
				sum_q   <= '0;
				tsq_q   <= '0;
				res_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.accept) begin
					if (room) begin
						count_q <= count_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (vld_s1) begin
					sum_q <= sum_q + {{(SUMW-SW){t_s1[SW-1]}}, t_s1};
					tsq_q <= tsq_q + TSQW'(tsq_s1);
					res_q <= res_q + RESW'(rsq_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_s1   <= samples.true_value;
			tsq_s1 <= tt[2*SW-2:0];
			rsq_s1 <= dd[2*SW-1:0];
		end

		if (cmd.mul_load) begin
			prod_q <= '0;
			unique case (cmd.mul_sel)
				r2sa_pkg::MSEL_N_SQ: begin
					mcand_q  <= PW'(tsq_q);
					mplier_q <= MPW'(count_q);
				end
				r2sa_pkg::MSEL_S_S: begin
					mcand_q  <= PW'(abs_s);
					mplier_q <= abs_s;
				end
				r2sa_pkg::MSEL_N_RES: begin
					mcand_q  <= PW'(res_q);
					mplier_q <= MPW'(count_q);
				end
				default: begin
					mcand_q  <= '0;
					mplier_q <= '0;
				end
			endcase
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= mplier_q >> 1;
		end

		if (cmd.den_set) begin
			den_q <= prod_q[DENW-1:0];
		end else if (cmd.den_sub) begin
			den_q <= den_q - prod_q[DENW-1:0];
		end

		if (cmd.num_load) begin
			rem_q <= REMW'(prod_q);
			dvs_q <= {den_q, 3'b000};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (cand - dvs_ext) : cand;
			quo_q <= {quo_q[QW-2:0], ge};
			if (cmd.div_shr) begin
				dvs_q <= dvs_q >> 1;
			end
		end

		if (cmd.check) begin
			cst_q <= den_zero;
			sat_q <= !den_zero && over;
		end

		if (cmd.finish) begin
			r2_value_q  <= r2_next;
			saturated_q <= sat_q && !cst_q;
			constant_q  <= cst_q;
			overflow_q  <= ovf_q;
			count_out_q <= r2sa_pkg::COUNT_OUT_BITS'(count_q);
		end
	end

	assign scores.r2_value        = r2_value_q;
	assign scores.saturated       = saturated_q;
	assign scores.constant_target = constant_q;
	assign scores.count_overflow  = overflow_q;
	assign scores.sample_count    = count_out_q;

endmodule

// ===== rtl/r2sa_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2sa_ctrl: sequencer of the R2 score accumulator
// Runs accumulation, the three closing products, the range check and the
// divide, and owns both handshakes.
// ----------------------------------------------------------------------------
module r2sa_ctrl #(
	parameter int FRAC_BITS = r2sa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  r2sa_pkg::status_t  status,
	output r2sa_pkg::cmd_t     cmd
);
	localparam int DIV_STEPS = FRAC_BITS + r2sa_pkg::R2_INT_BITS;
	localparam int CNTW      = $clog2(DIV_STEPS);

	r2sa_pkg::state_t state_q, state_d;
	logic [CNTW-1:0]  div_cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = state_q == r2sa_pkg::ST_ACCUM;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= r2sa_pkg::ST_ACCUM;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.check) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + CNTW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = r2sa_pkg::MSEL_N_SQ;
		cmd.div_frac = div_cnt_q >= CNTW'(r2sa_pkg::R2_INT_BITS);
		cmd.div_shr  = div_cnt_q < CNTW'(r2sa_pkg::R2_INT_BITS - 1);
		unique case (state_q)
			r2sa_pkg::ST_ACCUM: begin
				cmd.accept = in_valid;
				if (in_valid && status.in_last) begin
					state_d = r2sa_pkg::ST_DRAIN;
				end
			end
			r2sa_pkg::ST_DRAIN: begin
				state_d = r2sa_pkg::ST_LOAD;
			end
			r2sa_pkg::ST_LOAD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_sel  = r2sa_pkg::MSEL_N_SQ;
				state_d      = r2sa_pkg::ST_MUL_NSQ;
			end
			r2sa_pkg::ST_MUL_NSQ: begin
				if (status.mul_done) begin
					cmd.den_set  = 1'b1;
					cmd.mul_load = 1'b1;
					cmd.mul_sel  = r2sa_pkg::MSEL_S_S;
					state_d      = r2sa_pkg::ST_MUL_SS;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			r2sa_pkg::ST_MUL_SS: begin
				if (status.mul_done) begin
					cmd.den_sub  = 1'b1;
					cmd.mul_load = 1'b1;
					cmd.mul_sel  = r2sa_pkg::MSEL_N_RES;
					state_d      = r2sa_pkg::ST_MUL_NRES;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			r2sa_pkg::ST_MUL_NRES: begin
				if (status.mul_done) begin
					cmd.num_load = 1'b1;
					state_d      = r2sa_pkg::ST_CHECK;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			r2sa_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = status.skip_div ? r2sa_pkg::ST_FINISH : r2sa_pkg::ST_DIV;
			end
			r2sa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == CNTW'(DIV_STEPS - 1)) begin
					state_d = r2sa_pkg::ST_FINISH;
				end
			end
			r2sa_pkg::ST_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = r2sa_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = r2sa_pkg::ST_ACCUM;
			end
		endcase
	end

	// a closing pair stops intake until the score is written
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && status.in_last) |=> !in_ready)
		else $error("intake open after closing pair");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> slot_free)
		else $error("score overwritten before transfer");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == r2sa_pkg::ST_FINISH))
		else $error("score valid without finish");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == r2sa_pkg::ST_DIV) |-> (div_cnt_q <= CNTW'(DIV_STEPS - 1)))
		else $error("divide step count out of range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (state_q == r2sa_pkg::ST_ACCUM))
		else $error("pair taken while closing a set");

endmodule

// ===== rtl/r2_score_accumulator.sv =====
// ----------------------------------------------------------------------------
// r2_score_accumulator: streaming coefficient of determination (R2)
// Sums one true/predicted pair per cycle and, on the pair marked last,
// returns R2 = 1 - n*ss_res/(n*sum_sq - sum^2) in signed Q.FRAC_BITS.
// ----------------------------------------------------------------------------
// Usage:
//   samples: valid/ready channel, one pair per transfer, last closes a set.
//   scores:  valid/ready channel, one score per closed set, with flags
//            (saturated below -8.0, constant target, pairs dropped past
//            MAX_SAMPLES) and the number of pairs that were counted.
//   Throughput: one pair per cycle inside a set. After the last pair the
//   intake closes while the score is formed by one shift-add multiplier
//   and a restoring divider, one step per cycle. Constant-target and
//   saturated sets skip the FRAC_BITS + 4 divide steps.
//   The score sits in an output register; intake reopens as soon as it is
//   written, and the next set accumulates while the receiver stalls. A set
//   that closes before the previous score is taken waits in the finish step.
//   Reset clears all sums and returns the block to intake; no score pending.
// ----------------------------------------------------------------------------
module r2_score_accumulator #(
	parameter int MAX_SAMPLES = r2sa_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = r2sa_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = r2sa_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	r2sa_in_if.sink     samples,
	r2sa_out_if.source  scores
);
	r2sa_pkg::cmd_t    cmd;
	r2sa_pkg::status_t status;
	logic              in_ready;
	logic              out_valid;

	assign samples.ready = in_ready;
	assign scores.valid  = out_valid;

	r2sa_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (scores.ready),
		.status    (status),
		.cmd       (cmd)
	);

	r2sa_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.samples (samples),
		.scores  (scores)
	);

endmodule

// ===== test/tb_r2_score_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_r2_score_accumulator: self-checking bench for the streaming R2 score
// Feeds sets of true/predicted pairs through the sample channel with random
// gaps and stalls, scores each closed set with an exact integer predictor,
// and checks every field of every score in order.
// ----------------------------------------------------------------------------
module tb_r2_score_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB        = r2sa_pkg::SAMPLE_BITS_DEF;
	localparam int FB        = r2sa_pkg::FRAC_BITS_DEF;
	localparam int R2W       = FB + r2sa_pkg::R2_INT_BITS;
	localparam int CW        = r2sa_pkg::COUNT_OUT_BITS;
	localparam int MAX_PAIRS = r2sa_pkg::MAX_SAMPLES_DEF;
	localparam int RANDOM_PAIRS = 600;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 150;

	typedef enum int {
		SET_NOISE,
		SET_FIT,
		SET_FLAT,
		SET_EXTREME
	} set_kind_t;

	typedef struct {
		logic signed [SB-1:0] true_value;
		logic signed [SB-1:0] predicted_value;
		logic                 fin;
		int unsigned          gap;
	} pair_t;

	typedef struct {
		logic signed [R2W-1:0] r2_value;
		logic                  saturated;
		logic                  constant_target;
		logic                  count_overflow;
		logic [CW-1:0]         sample_count;
	} score_t;

	logic clk = 1'b0;
	logic arst_n;

	r2sa_in_if  samples_if ();
	r2sa_out_if scores_if ();

	r2_score_accumulator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.scores (scores_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pair_t  pair_queue[$];
	score_t score_queue[$];

	// running sums of the open set
	int           acc_count;
	longint       acc_sum;
	logic [127:0] acc_sq;
	logic [127:0] acc_res;
	logic         acc_dropped;

	int fail_count;
	int pairs_sent;
	int sets_checked;
	int sat_seen;
	int flat_seen;
	int drop_seen;
	int idle_cycles;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rand_sample();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic void clear_sums();
		acc_count   = 0;
		acc_sum     = 0;
		acc_sq      = '0;
		acc_res     = '0;
		acc_dropped = 1'b0;
	endfunction

	// Folds one pair into the sums; on the closing pair scores the set
	// as 1 - n*ss_res/(n*sum_sq - sum^2), floored to Q.FB.
	function automatic void absorb_pair(logic signed [SB-1:0] t, logic signed [SB-1:0] p,
		logic fin);
		longint       tl;
		longint       dl;
		logic [127:0] nn;
		logic [127:0] mag_sum;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		score_t       s;
		tl = longint'(t);
		dl = tl - longint'(p);
		if (acc_count < MAX_PAIRS) begin
			acc_count++;
			acc_sum += tl;
			acc_sq  += 128'(tl * tl);
			acc_res += 128'(dl * dl);
		end else begin
			acc_dropped = 1'b1;
		end
		if (!fin)
			return;
		nn      = 128'(acc_count);
		mag_sum = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
		den     = nn * acc_sq - mag_sum * mag_sum;
		num     = nn * acc_res;
		s.saturated       = 1'b0;
		s.constant_target = 1'b0;
		if (den == 0) begin
			s.r2_value        = R2W'(longint'(1) << FB);
			s.constant_target = 1'b1;
		end else if (num > den * 128'd9) begin
			s.r2_value  = R2W'(-(longint'(8) << FB));
			s.saturated = 1'b1;
		end else begin
			// ceiling of the scaled ratio gives the floor of the score
			q = ((num << FB) + den - 128'd1) / den;
			s.r2_value = R2W'((128'd1 << FB) - q);
		end
		s.count_overflow = acc_dropped;
		s.sample_count   = CW'(acc_count);
		score_queue.push_back(s);
		clear_sums();
	endfunction

	function automatic void queue_pair(int t, int p, bit fin, bit quiet);
		pair_t it;
		it.true_value      = SB'(t);
		it.predicted_value = SB'(p);
		it.fin             = fin;
		it.gap             = quiet ? 0 : pick_gap();
		pair_queue.push_back(it);
	endfunction

	function automatic void make_set(int len, set_kind_t kind, bit quiet);
		int base;
		int t;
		int p;
		int sh;
		int extremes[4];
		extremes = '{-32768, 32767, 0, -1};
		base = rand_sample();
		sh   = $urandom_range(3, 15);
		for (int i = 0; i < len; i++) begin
			case (kind)
				SET_FIT: begin
					t = rand_sample() >>> $urandom_range(0, 8);
					p = t + (rand_sample() >>> sh);
					if (p > 32767)
						p = 32767;
					if (p < -32768)
						p = -32768;
				end
				SET_FLAT: begin
					t = base;
					p = rand_sample();
				end
				SET_EXTREME: begin
					t = extremes[$urandom_range(0, 3)];
					p = extremes[$urandom_range(0, 3)];
				end
				default: begin
					t = rand_sample();
					p = rand_sample();
				end
			endcase
			queue_pair(t, p, i == len - 1, quiet);
		end
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin : drive_blk
		pair_t it;
		if (!arst_n) begin
			samples_if.valid           <= 1'b0;
			samples_if.true_value      <= '0;
			samples_if.predicted_value <= '0;
			samples_if.last            <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				absorb_pair(samples_if.true_value, samples_if.predicted_value,
					samples_if.last);
				pairs_sent++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (pair_queue.size() == 0) begin
					samples_if.valid <= 1'b0;
				end else if (pair_queue[0].gap != 0) begin
					pair_queue[0].gap = pair_queue[0].gap - 1;
					samples_if.valid <= 1'b0;
				end else begin
					it = pair_queue.pop_front();
					samples_if.valid           <= 1'b1;
					samples_if.true_value      <= it.true_value;
					samples_if.predicted_value <= it.predicted_value;
					samples_if.last            <= it.fin;
				end
			end
		end
	end

	// score receiver: stalls come in phases, some stretches never stall
	int unsigned stall_left;
	logic [7:0]  sink_cycle;
	logic        sink_stalls;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scores_if.ready <= 1'b0;
			stall_left      <= 0;
			sink_cycle      <= '0;
			sink_stalls     <= 1'b1;
		end else begin
			sink_cycle <= sink_cycle + 8'd1;
			if (sink_cycle == 8'd0)
				sink_stalls <= ($urandom_range(0, 3) != 0);
			if (stall_left != 0) begin
				scores_if.ready <= 1'b0;
				stall_left      <= stall_left - 1;
			end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
				scores_if.ready <= 1'b0;
				stall_left      <= ($urandom_range(0, 4) != 0) ? $urandom_range(0, 2)
					: $urandom_range(8, 60);
			end else begin
				scores_if.ready <= 1'b1;
			end
		end
	end

	// score checker
	always @(posedge clk) begin : check_blk
		score_t s;
		if (arst_n && scores_if.valid && scores_if.ready) begin
			if (score_queue.size() == 0) begin
				$error("score transfer with no closed set pending");
				fail_count++;
			end else begin
				s = score_queue.pop_front();
				sets_checked++;
				if (s.saturated)
					sat_seen++;
				if (s.constant_target)
					flat_seen++;
				if (s.count_overflow)
					drop_seen++;
				if (scores_if.r2_value !== s.r2_value) begin
					$error("r2_value: expected %0d, got %0d", s.r2_value, scores_if.r2_value);
					fail_count++;
				end
				if (scores_if.saturated !== s.saturated) begin
					$error("saturated: expected %0b, got %0b", s.saturated,
						scores_if.saturated);
					fail_count++;
				end
				if (scores_if.constant_target !== s.constant_target) begin
					$error("constant_target: expected %0b, got %0b", s.constant_target,
						scores_if.constant_target);
					fail_count++;
				end
				if (scores_if.count_overflow !== s.count_overflow) begin
					$error("count_overflow: expected %0b, got %0b", s.count_overflow,
						scores_if.count_overflow);
					fail_count++;
				end
				if (scores_if.sample_count !== s.sample_count) begin
					$error("sample_count: expected %0d, got %0d", s.sample_count,
						scores_if.sample_count);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles without a transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready)
			|| (scores_if.valid && scores_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int        random_pairs;
		int        len;
		int        r;
		set_kind_t kind;
		arst_n                     = 1'b0;
		samples_if.valid           = 1'b0;
		samples_if.true_value      = '0;
		samples_if.predicted_value = '0;
		samples_if.last            = 1'b0;
		scores_if.ready            = 1'b0;
		fail_count   = 0;
		pairs_sent   = 0;
		sets_checked = 0;
		sat_seen     = 0;
		flat_seen    = 0;
		drop_seen    = 0;
		idle_cycles  = 0;
		clear_sums();

		// single pair: constant target
		queue_pair(1234, -5, 1, 0);
		// constant most-negative targets
		queue_pair(-32768, 32767, 0, 0);
		queue_pair(-32768, 0, 0, 0);
		queue_pair(-32768, -32768, 1, 0);
		// perfect prediction across the range
		queue_pair(-32768, -32768, 0, 0);
		queue_pair(32767, 32767, 0, 0);
		queue_pair(0, 0, 0, 0);
		queue_pair(100, 100, 1, 0);
		// predicting the mean: score zero
		queue_pair(10, 0, 0, 0);
		queue_pair(-10, 0, 1, 0);
		// exactly -8.0, not saturated
		queue_pair(1, -2, 0, 0);
		queue_pair(-1, 2, 1, 0);
		// just below -8.0
		queue_pair(1, -2, 0, 0);
		queue_pair(-1, 3, 1, 0);
		// worst residuals on tiny targets
		queue_pair(0, 32767, 0, 0);
		queue_pair(1, -32768, 1, 0);
		// full-scale targets against opposite extremes
		queue_pair(32767, -32768, 0, 0);
		queue_pair(-32768, 32767, 0, 0);
		queue_pair(32767, 32767, 0, 0);
		queue_pair(-1, 0, 1, 0);

		random_pairs = 0;
		while (random_pairs < RANDOM_PAIRS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			r   = $urandom_range(0, 9);
			if (r < 4)
				kind = SET_FIT;
			else if (r < 6)
				kind = SET_NOISE;
			else if (r < 7)
				kind = SET_FLAT;
			else
				kind = SET_EXTREME;
			make_set(len, kind, $urandom_range(0, 3) == 0);
			random_pairs += len;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pair_queue.size() != 0 || samples_if.valid)
			@(posedge clk);
		while (score_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d sample pairs and checked %0d set scores", pairs_sent,
			sets_checked);
		$display("  %0d saturated, %0d constant-target, %0d with pairs past the limit",
			sat_seen, flat_seen, drop_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
